FILE: sv/scanline_pixel_grid_darkener_unit_defines.svh
// Assertion macros shared by the darkener RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SCANLINE_PIXEL_GRID_DARKENER_UNIT_DEFINES_SVH
`define SCANLINE_PIXEL_GRID_DARKENER_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define SPGD_ASSERT_IMPLIES(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("spgd: same-cycle check failed");

// Next-cycle implication check.
`define SPGD_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("spgd: next-cycle check failed");

`endif

FILE: sv/spgd_pkg.sv
// Types, constants and factor functions for the scanline pixel grid darkener.
// No dependencies; every module and interface of the block imports this package.
package spgd_pkg;

   // Geometry register width and row phase register width.
   localparam int DIM_W     = 13;
   localparam int PHASE_W   = 12;
   localparam int CSR_IDX_W = 3;

   // Channel and factor widths; a factor of 256 is unity.
   localparam int CH_W      = 8;
   localparam int NUM_LANES = 4;
   localparam int FAC_W     = 9;
   localparam int GRADES    = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PHASE = 3'd4;

   // Base darkening factor for vertical scale 1, 2, 3 and 4 or more.
   localparam logic [FAC_W-1:0] UNITY_FACTOR = 9'd256;
   localparam logic [FAC_W-1:0] ROW_DARKEN   = 9'd32;
   localparam logic [FAC_W-1:0] BASE_FACTOR [GRADES] = '{9'd248, 9'd240, 9'd230, 9'd220};

   typedef logic [1:0] grade_type;
   typedef logic [NUM_LANES-1:0][CH_W-1:0] pixel_type;

   // Control that travels with a pixel through the lane pipeline.
   typedef struct packed {
      logic valid;
      logic boundary;
      logic row_end;
   } token_type;

   // One entry of the result queue.
   typedef struct packed {
      logic      row_end;
      pixel_type pixel;
   } result_type;

   // Divider command and answer.
   typedef struct packed {
      logic             start;
      logic [DIM_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] quotient;
      logic [DIM_W-1:0] remainder;
   } div_rsp_type;

   // Sequencer that recomputes the derived geometry after a register write.
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MULT,
      SEQ_PHASE,
      SEQ_START,
      SEQ_RMOD,
      SEQ_ACC
   } seq_state_type;

   // Factor applied on rows of phase zero.
   function automatic logic [FAC_W-1:0] row_factor(grade_type grade);
      return BASE_FACTOR[grade] - ROW_DARKEN;
   endfunction

   // Factor applied at a column boundary.
   function automatic logic [FAC_W-1:0] col_factor(grade_type grade);
      return BASE_FACTOR[grade] + ((UNITY_FACTOR - BASE_FACTOR[grade]) >> 1);
   endfunction

   // Factor applied on the last phase row at scale four and up.
   function automatic logic [FAC_W-1:0] alt_factor(grade_type grade);
      return UNITY_FACTOR - ((UNITY_FACTOR - BASE_FACTOR[grade]) >> 2);
   endfunction

endpackage

FILE: sv/spgd_req_if.sv
// Pixel input channel: valid/ready handshake with one RGBA pixel per transfer.
// Depends on spgd_pkg.
interface spgd_req_if;
   import spgd_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic [CH_W-1:0] alpha;
   logic            last_of_band;

   modport source (output valid, red, green, blue, alpha, last_of_band, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_of_band, output ready);
endinterface

FILE: sv/spgd_rsp_if.sv
// Result channel: valid/ready handshake with one processed pixel per transfer.
// Depends on spgd_pkg.
interface spgd_rsp_if;
   import spgd_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_blue;
   logic [CH_W-1:0] out_alpha;
   logic            row_end;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, row_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, row_end, output ready);
endinterface

FILE: sv/scanline_pixel_grid_darkener_unit.sv
// Top level of the scanline pixel grid darkener.
// Depends on spgd_pkg, spgd_req_if, spgd_rsp_if, spgd_divider, spgd_lane,
// spgd_merge and the assertion macro header.
//
// Usage:
//  - req_ch carries one RGBA pixel per transfer plus last_of_band; rsp_ch
//    returns processed pixels, row_end set on the last pixel of a row.
//  - Registers are written through csr_we/csr_index/csr_wdata while the
//    block is idle. Each write starts a recompute of the vertical scale and
//    the column and phase remainders on a shared 13-step divider: five
//    divisions, with req_ch.ready low while they run.
//  - Throughput is one pixel per cycle while no recompute runs and the
//    result queue has room. A pixel is held back until the next pixel of
//    its row arrives (or leaves at once if it ends the row); it passes the
//    row and column product registers before it enters the result queue.
//  - Reset loads the register defaults (1, 1, 1, 1, 0), clears the held
//    pixel, the column position and the row phase; no recompute is needed.
//  - A stalled receiver fills the four-entry result queue; req_ch.ready
//    drops while more than two results wait, and no result is lost.
`include "scanline_pixel_grid_darkener_unit_defines.svh"

module scanline_pixel_grid_darkener_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   spgd_req_if.sink                        req_ch,
   spgd_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [spgd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spgd_pkg::DIM_W-1:0]      csr_wdata
);
   import spgd_pkg::*;

   localparam int CNT_W = $clog2(MAX_WIDTH);

   // Configuration registers.
   logic [DIM_W-1:0]   out_width_ff, out_width_in;
   logic [DIM_W-1:0]   out_height_ff, out_height_in;
   logic [DIM_W-1:0]   src_width_ff, src_width_in;
   logic [DIM_W-1:0]   src_height_ff, src_height_in;
   logic [PHASE_W-1:0] start_phase_ff, start_phase_in;

   // Derived geometry and stream position.
   logic [DIM_W-1:0]   mult_ff, mult_in;
   logic [DIM_W-1:0]   phase_mod_ff, phase_mod_in;
   logic [DIM_W-1:0]   start_mod_ff, start_mod_in;
   logic [DIM_W-1:0]   r_mod_ff, r_mod_in;
   logic [DIM_W-1:0]   acc_ff, acc_in;
   logic [DIM_W-1:0]   row_phase_ff, row_phase_in;
   logic [CNT_W-1:0]   col_count_ff, col_count_in;
   seq_state_type      seq_state_ff, seq_state_in;
   logic               launch_ff, launch_in;

   // Lane pipeline control.
   token_type          s1_tok_ff, s1_tok_in;
   token_type          s2_tok_ff, s2_tok_in;
   logic [FAC_W-1:0]   s1_col_fac_ff, s1_col_fac_in;

   logic [DIM_W-1:0]   w_cl;
   logic [DIM_W-1:0]   gap;
   logic               pass_mode;
   logic               cols;
   logic               boundary;
   logic               alt_row;
   logic               row_end;
   grade_type          grade;
   logic [FAC_W-1:0]   row_fac;
   logic [FAC_W-1:0]   col_fac;
   logic [DIM_W:0]     acc_sum;
   logic [DIM_W-1:0]   acc_next;
   logic [DIM_W-1:0]   phase_inc;
   logic [DIM_W-1:0]   phase_wrap;
   logic               seq_idle;
   logic               can_advance;
   logic               accept;
   logic               capture;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   pixel_type          in_pixel;
   pixel_type          cur_pixel;

   // Geometry decode from the registers.
   always_comb begin
      if (out_width_ff == '0) begin
         w_cl = DIM_W'(1);
      end else if (32'(out_width_ff) > MAX_WIDTH) begin
         w_cl = DIM_W'(MAX_WIDTH);
      end else begin
         w_cl = out_width_ff;
      end
      pass_mode = (src_height_ff == '0) || (out_height_ff < src_height_ff) ||
                  (w_cl < src_width_ff) ||
                  ((out_height_ff == src_height_ff) && (w_cl == src_width_ff));
      cols      = !pass_mode && (w_cl > src_width_ff) && (src_width_ff != '0);
      gap       = w_cl - src_width_ff;
      boundary  = cols && ((acc_ff == '0) || (acc_ff > gap));
      grade     = (mult_ff >= DIM_W'(4)) ? grade_type'(3) : grade_type'(mult_ff[1:0] - 2'd1);
      alt_row   = (mult_ff >= DIM_W'(4)) && (phase_mod_ff == mult_ff - DIM_W'(1));
      if (pass_mode) begin
         row_fac = UNITY_FACTOR;
      end else if (phase_mod_ff == '0) begin
         row_fac = row_factor(grade);
      end else if (alt_row) begin
         row_fac = alt_factor(grade);
      end else begin
         row_fac = UNITY_FACTOR;
      end
      col_fac    = boundary ? col_factor(grade) : UNITY_FACTOR;
      row_end    = req_ch.last_of_band || (32'(col_count_ff) + 32'd1 >= 32'(w_cl));
      acc_sum    = {1'b0, acc_ff} + {1'b0, r_mod_ff};
      acc_next   = (acc_sum >= {1'b0, w_cl}) ? DIM_W'(acc_sum - {1'b0, w_cl})
                                             : DIM_W'(acc_sum);
      phase_inc  = phase_mod_ff + DIM_W'(1);
      phase_wrap = (phase_inc == mult_ff) ? '0 : phase_inc;
   end

   // Input handshake.
   assign seq_idle     = seq_state_ff == SEQ_IDLE;
   assign req_ch.ready = seq_idle && !csr_we && can_advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign capture      = div_rsp.done && !launch_ff;

   // Sequencer, stream position and register writes.
   always_comb begin
      out_width_in   = out_width_ff;
      out_height_in  = out_height_ff;
      src_width_in   = src_width_ff;
      src_height_in  = src_height_ff;
      start_phase_in = start_phase_ff;
      mult_in        = mult_ff;
      phase_mod_in   = phase_mod_ff;
      start_mod_in   = start_mod_ff;
      r_mod_in       = r_mod_ff;
      acc_in         = acc_ff;
      row_phase_in   = row_phase_ff;
      col_count_in   = col_count_ff;
      seq_state_in   = seq_state_ff;
      launch_in      = 1'b0;
      div_req.start    = launch_ff && !seq_idle;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      case (seq_state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (row_end) begin
                  col_count_in = '0;
                  acc_in       = '0;
                  if (!pass_mode) begin
                     phase_mod_in = phase_wrap;
                     row_phase_in = phase_wrap;
                  end
                  if (req_ch.last_of_band) begin
                     row_phase_in = {1'b0, start_phase_ff};
                     phase_mod_in = start_mod_ff;
                  end
               end else begin
                  col_count_in = col_count_ff + CNT_W'(1);
                  acc_in       = acc_next;
               end
            end
         end
         SEQ_MULT: begin
            div_req.dividend = out_height_ff;
            div_req.divisor  = src_height_ff;
            if (capture) begin
               mult_in      = div_rsp.quotient;
               seq_state_in = SEQ_PHASE;
               launch_in    = 1'b1;
            end
         end
         SEQ_PHASE: begin
            div_req.dividend = row_phase_ff;
            div_req.divisor  = mult_ff;
            if (capture) begin
               phase_mod_in = div_rsp.remainder;
               seq_state_in = SEQ_START;
               launch_in    = 1'b1;
            end
         end
         SEQ_START: begin
            div_req.dividend = {1'b0, start_phase_ff};
            div_req.divisor  = mult_ff;
            if (capture) begin
               start_mod_in = div_rsp.remainder;
               seq_state_in = SEQ_RMOD;
               launch_in    = 1'b1;
            end
         end
         SEQ_RMOD: begin
            div_req.dividend = src_width_ff;
            div_req.divisor  = w_cl;
            if (capture) begin
               r_mod_in     = div_rsp.remainder;
               seq_state_in = SEQ_ACC;
               launch_in    = 1'b1;
            end
         end
         SEQ_ACC: begin
            div_req.dividend = acc_ff;
            div_req.divisor  = w_cl;
            if (capture) begin
               acc_in       = div_rsp.remainder;
               seq_state_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_state_in = SEQ_IDLE;
         end
      endcase

      // A register write restarts the recompute from the top.
      if (csr_we) begin
         seq_state_in = SEQ_MULT;
         launch_in    = 1'b1;
         case (csr_index)
            CSR_OUT_WIDTH:   out_width_in   = csr_wdata;
            CSR_OUT_HEIGHT:  out_height_in  = csr_wdata;
            CSR_SRC_WIDTH:   src_width_in   = csr_wdata;
            CSR_SRC_HEIGHT:  src_height_in  = csr_wdata;
            CSR_START_PHASE: start_phase_in = csr_wdata[PHASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Tokens move through the lane pipeline with the data.
   always_comb begin
      s1_tok_in     = s1_tok_ff;
      s2_tok_in     = s2_tok_ff;
      s1_col_fac_in = s1_col_fac_ff;
      if (can_advance) begin
         s1_tok_in     = '{valid: accept, boundary: boundary, row_end: row_end};
         s1_col_fac_in = col_fac;
         s2_tok_in     = s1_tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff   <= DIM_W'(1);
         out_height_ff  <= DIM_W'(1);
         src_width_ff   <= DIM_W'(1);
         src_height_ff  <= DIM_W'(1);
         start_phase_ff <= '0;
         mult_ff        <= DIM_W'(1);
         phase_mod_ff   <= '0;
         start_mod_ff   <= '0;
         r_mod_ff       <= '0;
         acc_ff         <= '0;
         row_phase_ff   <= '0;
         col_count_ff   <= '0;
         seq_state_ff   <= SEQ_IDLE;
         launch_ff      <= 1'b0;
         s1_tok_ff      <= '0;
         s2_tok_ff      <= '0;
      end else begin
         out_width_ff   <= out_width_in;
         out_height_ff  <= out_height_in;
         src_width_ff   <= src_width_in;
         src_height_ff  <= src_height_in;
         start_phase_ff <= start_phase_in;
         mult_ff        <= mult_in;
         phase_mod_ff   <= phase_mod_in;
         start_mod_ff   <= start_mod_in;
         r_mod_ff       <= r_mod_in;
         acc_ff         <= acc_in;
         row_phase_ff   <= row_phase_in;
         col_count_ff   <= col_count_in;
         seq_state_ff   <= seq_state_in;
         launch_ff      <= launch_in;
         s1_tok_ff      <= s1_tok_in;
         s2_tok_ff      <= s2_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_fac_ff <= s1_col_fac_in;
   end

   // Shared divider for the geometry recompute.
   spgd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Four channel lanes.
   assign in_pixel[0] = req_ch.red;
   assign in_pixel[1] = req_ch.green;
   assign in_pixel[2] = req_ch.blue;
   assign in_pixel[3] = req_ch.alpha;

   for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_lane
      spgd_lane u_lane (
         .clock   (clock),
         .advance (can_advance),
         .ch_in   (in_pixel[lane]),
         .row_fac (row_fac),
         .col_fac (s1_col_fac_ff),
         .ch_out  (cur_pixel[lane])
      );
   end

   // Held pixel, boundary blend and result queue.
   spgd_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .tok         (s2_tok_ff),
      .cur_pixel   (cur_pixel),
      .can_advance (can_advance),
      .rsp_ch      (rsp_ch)
   );

   // The column remainder stays reduced by the current row length.
   `SPGD_ASSERT_IMPLIES(a_acc_reduced, clock, reset, seq_idle, acc_ff < w_cl)
   // The reduced row phase stays below the vertical scale when darkening.
   `SPGD_ASSERT_IMPLIES(a_phase_reduced, clock, reset, seq_idle && !pass_mode,
                        phase_mod_ff < mult_ff)
   // A divider answer only arrives while a recompute is running.
   `SPGD_ASSERT_IMPLIES(a_div_in_seq, clock, reset, div_rsp.done, !seq_idle)
   // Every register write restarts the recompute with a fresh division.
   `SPGD_ASSERT_NEXT(a_write_restarts, clock, reset, csr_we,
                     (seq_state_ff == SEQ_MULT) && launch_ff)

endmodule

FILE: sv/spgd_divider.sv
// Restoring divider, one quotient bit per cycle, for the geometry setup.
// Depends on spgd_pkg for the command and answer structs.
module spgd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  spgd_pkg::div_req_type div_req,
   output spgd_pkg::div_rsp_type div_rsp
);
   import spgd_pkg::*;

   localparam int STEP_W = $clog2(DIM_W + 1);

   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [DIM_W-1:0]  quo_ff, quo_in;
   logic [DIM_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIM_W:0]    shifted;
   logic [DIM_W:0]    trial;

   // Shift in the next dividend bit and try a subtraction.
   always_comb begin
      shifted    = {rem_ff, quo_ff[DIM_W-1]};
      trial      = shifted - {1'b0, divisor_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
         step_in    = STEP_W'(DIM_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = trial[DIM_W-1:0];
            quo_in = {quo_ff[DIM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIM_W-1:0];
            quo_in = {quo_ff[DIM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: sv/spgd_lane.sv
// One channel lane: row darkening multiply, then column darkening multiply.
// Depends on spgd_pkg; four lanes run side by side in the top level.
module spgd_lane (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [spgd_pkg::CH_W-1:0]     ch_in,
   input  logic [spgd_pkg::FAC_W-1:0]    row_fac,
   input  logic [spgd_pkg::FAC_W-1:0]    col_fac,
   output logic [spgd_pkg::CH_W-1:0]     ch_out
);
   import spgd_pkg::*;

   // A channel times a factor of at most 256 stays below 2^16.
   localparam int PROD_W = 2 * CH_W;

   logic [PROD_W-1:0] row_prod_ff, row_prod_in;
   logic [PROD_W-1:0] col_prod_ff, col_prod_in;

   // Each product is registered before the next multiply.
   always_comb begin
      row_prod_in = row_prod_ff;
      col_prod_in = col_prod_ff;
      if (advance) begin
         row_prod_in = PROD_W'(PROD_W'(ch_in) * PROD_W'(row_fac));
         col_prod_in = PROD_W'(PROD_W'(row_prod_ff[PROD_W-1:CH_W]) * PROD_W'(col_fac));
      end
   end

   always_ff @(posedge clock) begin
      row_prod_ff <= row_prod_in;
      col_prod_ff <= col_prod_in;
   end

   assign ch_out = col_prod_ff[PROD_W-1:CH_W];

endmodule

FILE: sv/spgd_merge.sv
// Merging stage: holds back one pixel, blends it at a column boundary and
// queues up to two results per pixel. Depends on spgd_pkg and spgd_rsp_if.
module spgd_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  spgd_pkg::token_type  tok,
   input  spgd_pkg::pixel_type  cur_pixel,
   output logic                 can_advance,
   spgd_rsp_if.source           rsp_ch
);
   import spgd_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   result_type       queue_ff [QUEUE_DEPTH];
   result_type       queue_in [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   pixel_type        held_pixel_ff, held_pixel_in;
   logic             held_valid_ff, held_valid_in;
   pixel_type        blended;
   pixel_type        held_out;
   result_type       entry_a;
   result_type       entry_b;
   logic             take;
   logic             push_a;
   logic             push_b;
   logic             pop;
   logic [CH_W:0]    lane_sum [NUM_LANES];

   // Room for two results keeps the pipeline moving.
   assign can_advance = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign take        = can_advance && tok.valid;
   assign pop         = rsp_ch.valid && rsp_ch.ready;

   // Per-channel average of the held pixel and the darkened boundary pixel.
   always_comb begin
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         lane_sum[lane] = {1'b0, held_pixel_ff[lane]} + {1'b0, cur_pixel[lane]};
         blended[lane]  = lane_sum[lane][CH_W:1];
      end
      held_out = tok.boundary ? blended : held_pixel_ff;
   end

   // Queue the held pixel first, then the current one if it ends the row.
   always_comb begin
      entry_a = held_valid_ff ? '{row_end: 1'b0, pixel: held_out}
                              : '{row_end: 1'b1, pixel: cur_pixel};
      entry_b = '{row_end: 1'b1, pixel: cur_pixel};
      push_a  = take && (held_valid_ff || tok.row_end);
      push_b  = take && held_valid_ff && tok.row_end;

      queue_in  = queue_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push_a) begin
         queue_in[wr_ptr_ff] = entry_a;
         wr_ptr_in           = wr_ptr_ff + PTR_W'(1);
      end
      if (push_b) begin
         queue_in[wr_ptr_ff + PTR_W'(1)] = entry_b;
         wr_ptr_in                       = wr_ptr_ff + PTR_W'(2);
      end
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

      held_pixel_in = held_pixel_ff;
      held_valid_in = held_valid_ff;
      if (take) begin
         if (tok.row_end) begin
            held_valid_in = 1'b0;
            held_pixel_in = '0;
         end else begin
            held_valid_in = 1'b1;
            held_pixel_in = cur_pixel;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      queue_ff      <= queue_in;
      held_pixel_ff <= held_pixel_in;
   end

   // Head of the queue drives the result channel.
   assign rsp_ch.valid     = count_ff != '0;
   assign rsp_ch.out_red   = queue_ff[rd_ptr_ff].pixel[0];
   assign rsp_ch.out_green = queue_ff[rd_ptr_ff].pixel[1];
   assign rsp_ch.out_blue  = queue_ff[rd_ptr_ff].pixel[2];
   assign rsp_ch.out_alpha = queue_ff[rd_ptr_ff].pixel[3];
   assign rsp_ch.row_end   = queue_ff[rd_ptr_ff].row_end;

endmodule
